// File: rtl/core/llhb_pkg.sv
// ----------------------------------------------------------------------------
// llhb_pkg
// shared types, constants and the log bucket top rom of the histogram binner
// ----------------------------------------------------------------------------
package llhb_pkg;

  localparam int MAX_BUCKETS = 64;
  localparam int NUM_COUNTERS = MAX_BUCKETS + 1;
  localparam int BKT_W = 7;
  localparam int CNT_W = 32;
  localparam int SMP_W = 64;
  localparam int TOP_W = 24;
  localparam int ROM_IDX_W = $clog2(MAX_BUCKETS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DEC_W = 3;
  localparam int LOG_STEP = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LINEAR_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOG_DECADES = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [BKT_W-1:0] LINEAR_SIZE_RST = 7'd64;
  localparam logic [DEC_W-1:0] LOG_DECADES_RST = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RDMEM,
    ST_UPDATE
  } llhb_state_t;

  typedef struct packed {
    logic             log_mode;
    logic [BKT_W-1:0] linear_size;
    logic [DEC_W-1:0] log_decades;
  } llhb_cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic rd;
    logic commit;
  } llhb_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } llhb_sts_t;

  function automatic logic [TOP_W-1:0] log_top(input logic [ROM_IDX_W-1:0] idx);
    logic [TOP_W-1:0] t;
    unique case (idx)
      6'd0:  t = 24'd0;
      6'd1:  t = 24'd1;
      6'd2:  t = 24'd2;
      6'd3:  t = 24'd3;
      6'd4:  t = 24'd4;
      6'd5:  t = 24'd5;
      6'd6:  t = 24'd6;
      6'd7:  t = 24'd7;
      6'd8:  t = 24'd8;
      6'd9:  t = 24'd9;
      6'd10: t = 24'd10;
      6'd11: t = 24'd12;
      6'd12: t = 24'd15;
      6'd13: t = 24'd19;
      6'd14: t = 24'd25;
      6'd15: t = 24'd31;
      6'd16: t = 24'd39;
      6'd17: t = 24'd50;
      6'd18: t = 24'd63;
      6'd19: t = 24'd79;
      6'd20: t = 24'd100;
      6'd21: t = 24'd125;
      6'd22: t = 24'd158;
      6'd23: t = 24'd199;
      6'd24: t = 24'd251;
      6'd25: t = 24'd316;
      6'd26: t = 24'd398;
      6'd27: t = 24'd501;
      6'd28: t = 24'd630;
      6'd29: t = 24'd794;
      6'd30: t = 24'd1000;
      6'd31: t = 24'd1258;
      6'd32: t = 24'd1584;
      6'd33: t = 24'd1995;
      6'd34: t = 24'd2511;
      6'd35: t = 24'd3162;
      6'd36: t = 24'd3981;
      6'd37: t = 24'd5011;
      6'd38: t = 24'd6309;
      6'd39: t = 24'd7943;
      6'd40: t = 24'd10000;
      6'd41: t = 24'd12589;
      6'd42: t = 24'd15848;
      6'd43: t = 24'd19952;
      6'd44: t = 24'd25118;
      6'd45: t = 24'd31622;
      6'd46: t = 24'd39810;
      6'd47: t = 24'd50118;
      6'd48: t = 24'd63095;
      6'd49: t = 24'd79432;
      6'd50: t = 24'd100000;
      6'd51: t = 24'd125892;
      6'd52: t = 24'd158489;
      6'd53: t = 24'd199526;
      6'd54: t = 24'd251188;
      6'd55: t = 24'd316227;
      6'd56: t = 24'd398107;
      6'd57: t = 24'd501187;
      6'd58: t = 24'd630957;
      6'd59: t = 24'd794328;
      6'd60: t = 24'd1000000;
      6'd61: t = 24'd1258925;
      6'd62: t = 24'd1584893;
      6'd63: t = 24'd1995262;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/log_linear_histogram_binner.sv
// ----------------------------------------------------------------------------
// log_linear_histogram_binner: an accepted item passes search, counter read and counter
// update to a registered result, a log sample taking 1 to 7 binary search steps over the rom
// new items are taken only in idle, after a commit that waits while a held result stalls
// reset: counters read zero at once through per-bucket valid flags, no clearing pass
// ----------------------------------------------------------------------------
module log_linear_histogram_binner (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [llhb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [llhb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [llhb_pkg::SMP_W-1:0]        in_sample,
  input  logic [llhb_pkg::BKT_W-1:0]        in_read_bucket,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [llhb_pkg::BKT_W-1:0]        out_bucket,
  output logic [llhb_pkg::CNT_W-1:0]        out_count
);

  llhb_pkg::llhb_cfg_t cfg_r;
  llhb_pkg::llhb_cmd_t cmd;
  llhb_pkg::llhb_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_mode    <= 1'b0;
      cfg_r.linear_size <= llhb_pkg::LINEAR_SIZE_RST;
      cfg_r.log_decades <= llhb_pkg::LOG_DECADES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        llhb_pkg::CFG_IDX_LOG_MODE: begin
          cfg_r.log_mode <= cfg_wdata[0];
        end
        llhb_pkg::CFG_IDX_LINEAR_SIZE: begin
          cfg_r.linear_size <= cfg_wdata[llhb_pkg::BKT_W-1:0];
        end
        llhb_pkg::CFG_IDX_LOG_DECADES: begin
          cfg_r.log_decades <= cfg_wdata[llhb_pkg::DEC_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  llhb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  llhb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_sample      (in_sample),
    .in_read_bucket (in_read_bucket),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bucket     (out_bucket),
    .out_count      (out_count)
  );

endmodule

// File: rtl/core/llhb_ctrl.sv
// ----------------------------------------------------------------------------
// llhb_ctrl
// sequencer: accept, bucket search, counter read, counter update and result
// ----------------------------------------------------------------------------
module llhb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  llhb_pkg::llhb_sts_t sts,
  output llhb_pkg::llhb_cmd_t cmd
);

  llhb_pkg::llhb_state_t state_r;
  llhb_pkg::llhb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llhb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      llhb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = llhb_pkg::ST_SEARCH;
        end
      end
      llhb_pkg::ST_SEARCH: begin
        if (sts.done) begin
          state_nxt = llhb_pkg::ST_RDMEM;
        end
      end
      llhb_pkg::ST_RDMEM: begin
        state_nxt = llhb_pkg::ST_UPDATE;
      end
      llhb_pkg::ST_UPDATE: begin
        if (sts.out_free) begin
          state_nxt = llhb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = llhb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      llhb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      llhb_pkg::ST_SEARCH: begin
        cmd.step = !sts.done;
      end
      llhb_pkg::ST_RDMEM: begin
        cmd.rd = 1'b1;
      end
      llhb_pkg::ST_UPDATE: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/llhb_dp.sv
// ----------------------------------------------------------------------------
// llhb_dp
// datapath: bucket search unit, counter memory with valid flags, result register
// ----------------------------------------------------------------------------
module llhb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  llhb_pkg::llhb_cfg_t               cfg,
  input  llhb_pkg::llhb_cmd_t               cmd,
  output llhb_pkg::llhb_sts_t               sts,
  input  logic                              in_func,
  input  logic [llhb_pkg::SMP_W-1:0]        in_sample,
  input  logic [llhb_pkg::BKT_W-1:0]        in_read_bucket,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [llhb_pkg::BKT_W-1:0]        out_bucket,
  output logic [llhb_pkg::CNT_W-1:0]        out_count
);

  logic                          func_r;
  logic [llhb_pkg::SMP_W-1:0]    sample_r;
  logic [llhb_pkg::BKT_W-1:0]    lo_r;
  logic [llhb_pkg::BKT_W-1:0]    lo_nxt;
  logic [llhb_pkg::BKT_W-1:0]    hi_r;
  logic [llhb_pkg::BKT_W-1:0]    hi_nxt;
  logic [llhb_pkg::BKT_W-1:0]    n_log;
  logic [llhb_pkg::BKT_W-1:0]    n_raw;
  logic [llhb_pkg::BKT_W-1:0]    n_act;
  logic [llhb_pkg::BKT_W-1:0]    lin_bucket;
  logic [llhb_pkg::BKT_W:0]      mid_sum;
  logic [llhb_pkg::BKT_W-1:0]    mid;
  logic [llhb_pkg::TOP_W-1:0]    top_val;
  logic                          le_top;
  logic                          in_range;
  logic [llhb_pkg::CNT_W-1:0]    mem [llhb_pkg::NUM_COUNTERS];
  logic [llhb_pkg::NUM_COUNTERS-1:0] valid_r;
  logic [llhb_pkg::CNT_W-1:0]    rd_data_r;
  logic                          hit_r;
  logic [llhb_pkg::CNT_W-1:0]    cnt_base;
  logic [llhb_pkg::CNT_W-1:0]    cnt_new;
  logic                          out_valid_r;
  logic [llhb_pkg::BKT_W-1:0]    out_bucket_r;
  logic [llhb_pkg::CNT_W-1:0]    out_count_r;

  // active bucket count, clamped
  assign n_log = llhb_pkg::BKT_W'(cfg.log_decades * llhb_pkg::LOG_STEP + 1);
  assign n_raw = cfg.log_mode ? n_log : cfg.linear_size;
  assign n_act = (n_raw > llhb_pkg::BKT_W'(llhb_pkg::MAX_BUCKETS)) ?
                 llhb_pkg::BKT_W'(llhb_pkg::MAX_BUCKETS) : n_raw;
  assign lin_bucket = (in_sample < llhb_pkg::SMP_W'(n_act)) ?
                      in_sample[llhb_pkg::BKT_W-1:0] : n_act;

  // binary search step over the log rom
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[llhb_pkg::BKT_W:1];
  assign top_val = llhb_pkg::log_top(mid[llhb_pkg::ROM_IDX_W-1:0]);
  assign le_top  = sample_r <= llhb_pkg::SMP_W'(top_val);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load) begin
      if (in_func == llhb_pkg::FUNC_READ) begin
        lo_nxt = in_read_bucket;
        hi_nxt = in_read_bucket;
      end else if (!cfg.log_mode) begin
        lo_nxt = lin_bucket;
        hi_nxt = lin_bucket;
      end else begin
        lo_nxt = '0;
        hi_nxt = n_act;
      end
    end else if (cmd.step) begin
      if (le_top) begin
        hi_nxt = mid;
      end else begin
        lo_nxt = mid + llhb_pkg::BKT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.load) begin
      func_r   <= in_func;
      sample_r <= in_sample;
    end
  end

  assign sts.done = (lo_r == hi_r);

  // counter memory
  assign in_range = lo_r <= llhb_pkg::BKT_W'(llhb_pkg::MAX_BUCKETS);

  always_ff @(posedge clk) begin
    if (cmd.rd && in_range) begin
      rd_data_r <= mem[lo_r];
    end
    if (cmd.commit && func_r == llhb_pkg::FUNC_SAMPLE) begin
      mem[lo_r] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.rd) begin
        hit_r <= in_range && valid_r[lo_r];
      end
      if (cmd.commit && func_r == llhb_pkg::FUNC_SAMPLE) begin
        valid_r[lo_r] <= 1'b1;
      end
    end
  end

  assign cnt_base = hit_r ? rd_data_r : '0;
  assign cnt_new  = (func_r == llhb_pkg::FUNC_SAMPLE) ? cnt_base + llhb_pkg::CNT_W'(1) :
                    cnt_base;

  // result register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_bucket_r <= lo_r;
      out_count_r  <= cnt_new;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_bucket = out_bucket_r;
  assign out_count  = out_count_r;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (lo_r < hi_r) && (hi_r <= llhb_pkg::BKT_W'(llhb_pkg::MAX_BUCKETS)))
    else $error("search step with empty or oversized range");

  a_sample_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && func_r == llhb_pkg::FUNC_SAMPLE) |-> in_range)
    else $error("sample binned beyond the counter store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && (out_bucket_r == $past(lo_r)))
    else $error("committed result not presented");
`endif

endmodule
